@@ hdl/bbfa_pkg.sv @@
package bbfa_pkg;

    localparam int CAP_W = 17;
    localparam int CNT_W = 16;
    localparam int OUT_ID_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam int DEF_MAX_BATCHES = 16;

    localparam logic [CAP_W-1:0] DEF_VCAP_RESET = 17'd4096;
    localparam logic [CAP_W-1:0] DEF_ICAP_RESET = 17'd8192;

    localparam logic [CFG_IDX_W-1:0] CFG_DEF_VCAP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_ICAP = 1'd1;

    localparam logic FUNC_RESERVE = 1'b0;
    localparam logic FUNC_NEW_FRAME = 1'b1;

    // Smallest power of two that is not below n; zero and one both give one.
    function automatic logic [CAP_W-1:0] pow2_ceil(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] m;
        begin
            if (n <= 16'd1)
            begin
                pow2_ceil = 17'd1;
            end
            else
            begin
                m = n - 16'd1;
                m = m | (m >> 1);
                m = m | (m >> 2);
                m = m | (m >> 4);
                m = m | (m >> 8);
                pow2_ceil = {1'b0, m} + 17'd1;
            end
        end
    endfunction

    function automatic logic [CNT_W-1:0] sat16(input logic [CAP_W-1:0] v);
        begin
            sat16 = v[CAP_W-1] ? {CNT_W{1'b1}} : v[CNT_W-1:0];
        end
    endfunction

endpackage

@@ hdl/bbfa_ram.sv @@
module bbfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/bbfa_fit.sv @@
module bbfa_fit (
    input  logic [bbfa_pkg::CAP_W-1:0] vcap,
    input  logic [bbfa_pkg::CAP_W-1:0] icap,
    input  logic [bbfa_pkg::CAP_W-1:0] vcur,
    input  logic [bbfa_pkg::CAP_W-1:0] icur,
    input  logic [bbfa_pkg::CNT_W-1:0] vcount,
    input  logic [bbfa_pkg::CNT_W-1:0] icount,
    input  logic                       use_cursor,
    output logic                       fit
);
    import bbfa_pkg::*;

    logic [CAP_W-1:0] vroom;
    logic [CAP_W-1:0] iroom;

    // Active entries are tested on their remaining room, free entries on their capacity.
    assign vroom = vcap - (use_cursor ? vcur : '0);
    assign iroom = icap - (use_cursor ? icur : '0);
    assign fit = (vroom >= CAP_W'(vcount)) && (iroom >= CAP_W'(icount));

endmodule

@@ hdl/batch_buffer_first_fit_allocator.sv @@
// Batch buffer allocator. Each item is either a reserve request or a new-frame marker,
// and each gives exactly one result item. A reserve item walks the entry table once through
// its single read port, one entry per cycle, until an entry fits; a fitting free entry is
// moved into the active part, and a new entry is appended when none fits. The block stalls
// its input while an item is in work, and a finished result waits in an output register
// until it is taken.
module batch_buffer_first_fit_allocator #(
    parameter int MAX_BATCHES = bbfa_pkg::DEF_MAX_BATCHES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bbfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bbfa_pkg::CAP_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [bbfa_pkg::CNT_W-1:0]     vertex_count,
    input  logic [bbfa_pkg::CNT_W-1:0]     index_count,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bbfa_pkg::OUT_ID_W-1:0]  slot,
    output logic [bbfa_pkg::OUT_ID_W-1:0]  buffer_id,
    output logic [bbfa_pkg::CNT_W-1:0]     vertex_base,
    output logic [bbfa_pkg::CNT_W-1:0]     index_base,
    output logic                           created,
    output logic                           status
);
    import bbfa_pkg::*;

    localparam int SW = $clog2(MAX_BATCHES);
    localparam int CW = $clog2(MAX_BATCHES + 1);
    localparam int EW = 4 * CAP_W + SW;
    localparam int ICUR_LO = SW;
    localparam int VCUR_LO = SW + CAP_W;
    localparam int ICAP_LO = SW + 2 * CAP_W;
    localparam int VCAP_LO = SW + 3 * CAP_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BATCHES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_APPEND = 3'd2;
    localparam logic [2:0] S_RDDST  = 3'd3;
    localparam logic [2:0] S_WRSRC  = 3'd4;
    localparam logic [2:0] S_WRDST  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CAP_W-1:0] def_vcap_reg, def_vcap_next;
    logic [CAP_W-1:0] def_icap_reg, def_icap_next;
    logic [CW-1:0]    active_cnt_reg, active_cnt_next;
    logic [CW-1:0]    entry_cnt_reg, entry_cnt_next;
    logic [CW-1:0]    issue_idx_reg, issue_idx_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;

    logic [SW-1:0]    pend_idx_reg, pend_idx_next;
    logic [SW-1:0]    src_reg, src_next;
    logic [SW-1:0]    dst_reg, dst_next;
    logic [EW-1:0]    ent_reg, ent_next;
    logic [CNT_W-1:0] vcnt_reg, vcnt_next;
    logic [CNT_W-1:0] icnt_reg, icnt_next;
    logic [SW-1:0]    res_slot_reg, res_slot_next;
    logic [SW-1:0]    res_id_reg, res_id_next;
    logic [CNT_W-1:0] res_vbase_reg, res_vbase_next;
    logic [CNT_W-1:0] res_ibase_reg, res_ibase_next;
    logic             res_created_reg, res_created_next;
    logic             res_status_reg, res_status_next;
    logic [OUT_ID_W-1:0] slot_reg, slot_next;
    logic [OUT_ID_W-1:0] buffer_id_reg, buffer_id_next;
    logic [CNT_W-1:0] vertex_base_reg, vertex_base_next;
    logic [CNT_W-1:0] index_base_reg, index_base_next;
    logic             created_reg, created_next;
    logic             status_reg, status_next;

    logic             ram_we;
    logic [SW-1:0]    ram_waddr;
    logic [EW-1:0]    ram_wdata;
    logic [SW-1:0]    ram_raddr;
    logic [EW-1:0]    ram_rdata;

    logic [CAP_W-1:0] rd_vcap;
    logic [CAP_W-1:0] rd_icap;
    logic [CAP_W-1:0] rd_vcur;
    logic [CAP_W-1:0] rd_icur;
    logic [SW-1:0]    rd_id;
    logic             pend_active;
    logic             fit;
    logic             accept;
    logic [CAP_W-1:0] p2_vcap;
    logic [CAP_W-1:0] p2_icap;
    logic [CAP_W-1:0] new_vcap;
    logic [CAP_W-1:0] new_icap;

    assign rd_vcap = ram_rdata[VCAP_LO +: CAP_W];
    assign rd_icap = ram_rdata[ICAP_LO +: CAP_W];
    assign rd_vcur = ram_rdata[VCUR_LO +: CAP_W];
    assign rd_icur = ram_rdata[ICUR_LO +: CAP_W];
    assign rd_id   = ram_rdata[SW-1:0];

    assign pend_active = CW'(pend_idx_reg) < active_cnt_reg;

    assign p2_vcap  = pow2_ceil(vcnt_reg);
    assign p2_icap  = pow2_ceil(icnt_reg);
    assign new_vcap = (p2_vcap < def_vcap_reg) ? def_vcap_reg : p2_vcap;
    assign new_icap = (p2_icap < def_icap_reg) ? def_icap_reg : p2_icap;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    bbfa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BATCHES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bbfa_fit u_fit (
        .vcap       (rd_vcap),
        .icap       (rd_icap),
        .vcur       (rd_vcur),
        .icur       (rd_icur),
        .vcount     (vcnt_reg),
        .icount     (icnt_reg),
        .use_cursor (pend_active),
        .fit        (fit)
    );

    always_comb
    begin
        state_next       = state_reg;
        def_vcap_next    = def_vcap_reg;
        def_icap_next    = def_icap_reg;
        active_cnt_next  = active_cnt_reg;
        entry_cnt_next   = entry_cnt_reg;
        issue_idx_next   = issue_idx_reg;
        pend_next        = pend_reg;
        out_valid_next   = out_valid_reg && out_stall;
        pend_idx_next    = pend_idx_reg;
        src_next         = src_reg;
        dst_next         = dst_reg;
        ent_next         = ent_reg;
        vcnt_next        = vcnt_reg;
        icnt_next        = icnt_reg;
        res_slot_next    = res_slot_reg;
        res_id_next      = res_id_reg;
        res_vbase_next   = res_vbase_reg;
        res_ibase_next   = res_ibase_reg;
        res_created_next = res_created_reg;
        res_status_next  = res_status_reg;
        slot_next        = slot_reg;
        buffer_id_next   = buffer_id_reg;
        vertex_base_next = vertex_base_reg;
        index_base_next  = index_base_reg;
        created_next     = created_reg;
        status_next      = status_reg;
        ram_we           = 1'b0;
        ram_waddr        = dst_reg;
        ram_wdata        = ent_reg;
        ram_raddr        = issue_idx_reg[SW-1:0];

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEF_VCAP: def_vcap_next = cfg_data;
                CFG_DEF_ICAP: def_icap_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    vcnt_next        = vertex_count;
                    icnt_next        = index_count;
                    res_slot_next    = '0;
                    res_id_next      = '0;
                    res_vbase_next   = '0;
                    res_ibase_next   = '0;
                    res_created_next = 1'b0;
                    res_status_next  = 1'b0;
                    issue_idx_next   = '0;
                    pend_next        = 1'b0;
                    if (func == FUNC_NEW_FRAME)
                    begin
                        active_cnt_next = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (pend_reg && fit)
                begin
                    pend_next = 1'b0;
                    src_next  = pend_idx_reg;
                    res_id_next = rd_id;
                    if (pend_active)
                    begin
                        dst_next       = pend_idx_reg;
                        res_slot_next  = pend_idx_reg;
                        res_vbase_next = sat16(rd_vcur);
                        res_ibase_next = sat16(rd_icur);
                        ent_next = {rd_vcap, rd_icap, rd_vcur + CAP_W'(vcnt_reg),
                                    rd_icur + CAP_W'(icnt_reg), rd_id};
                        state_next = S_WRDST;
                    end
                    else
                    begin
                        dst_next        = active_cnt_reg[SW-1:0];
                        res_slot_next   = active_cnt_reg[SW-1:0];
                        active_cnt_next = active_cnt_reg + 1'b1;
                        ent_next = {rd_vcap, rd_icap, CAP_W'(vcnt_reg), CAP_W'(icnt_reg), rd_id};
                        state_next = (pend_idx_reg == active_cnt_reg[SW-1:0]) ? S_WRDST : S_RDDST;
                    end
                end
                else if (issue_idx_reg < entry_cnt_reg)
                begin
                    pend_next      = 1'b1;
                    pend_idx_next  = issue_idx_reg[SW-1:0];
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                if (entry_cnt_reg == MAX_CNT)
                begin
                    res_status_next = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    src_next         = entry_cnt_reg[SW-1:0];
                    dst_next         = active_cnt_reg[SW-1:0];
                    res_slot_next    = active_cnt_reg[SW-1:0];
                    res_id_next      = entry_cnt_reg[SW-1:0];
                    res_created_next = 1'b1;
                    ent_next = {new_vcap, new_icap, CAP_W'(vcnt_reg), CAP_W'(icnt_reg),
                                entry_cnt_reg[SW-1:0]};
                    entry_cnt_next  = entry_cnt_reg + 1'b1;
                    active_cnt_next = active_cnt_reg + 1'b1;
                    state_next = (entry_cnt_reg == active_cnt_reg) ? S_WRDST : S_RDDST;
                end
            end
            S_RDDST:
            begin
                ram_raddr  = dst_reg;
                state_next = S_WRSRC;
            end
            S_WRSRC:
            begin
                ram_we     = 1'b1;
                ram_waddr  = src_reg;
                ram_wdata  = ram_rdata;
                state_next = S_WRDST;
            end
            S_WRDST:
            begin
                ram_we     = 1'b1;
                ram_waddr  = dst_reg;
                ram_wdata  = ent_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    slot_next        = OUT_ID_W'(res_slot_reg);
                    buffer_id_next   = OUT_ID_W'(res_id_reg);
                    vertex_base_next = res_vbase_reg;
                    index_base_next  = res_ibase_reg;
                    created_next     = res_created_reg;
                    status_next      = res_status_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            def_vcap_reg   <= DEF_VCAP_RESET;
            def_icap_reg   <= DEF_ICAP_RESET;
            active_cnt_reg <= '0;
            entry_cnt_reg  <= '0;
            issue_idx_reg  <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            def_vcap_reg   <= def_vcap_next;
            def_icap_reg   <= def_icap_next;
            active_cnt_reg <= active_cnt_next;
            entry_cnt_reg  <= entry_cnt_next;
            issue_idx_reg  <= issue_idx_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg    <= pend_idx_next;
        src_reg         <= src_next;
        dst_reg         <= dst_next;
        ent_reg         <= ent_next;
        vcnt_reg        <= vcnt_next;
        icnt_reg        <= icnt_next;
        res_slot_reg    <= res_slot_next;
        res_id_reg      <= res_id_next;
        res_vbase_reg   <= res_vbase_next;
        res_ibase_reg   <= res_ibase_next;
        res_created_reg <= res_created_next;
        res_status_reg  <= res_status_next;
        slot_reg        <= slot_next;
        buffer_id_reg   <= buffer_id_next;
        vertex_base_reg <= vertex_base_next;
        index_base_reg  <= index_base_next;
        created_reg     <= created_next;
        status_reg      <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign slot        = slot_reg;
    assign buffer_id   = buffer_id_reg;
    assign vertex_base = vertex_base_reg;
    assign index_base  = index_base_reg;
    assign created     = created_reg;
    assign status      = status_reg;

    a_active_within_entries: assert property (@(posedge clk) disable iff (!rst_n)
        active_cnt_reg <= entry_cnt_reg)
        else $error("active count exceeds entry count");

    a_entries_within_table: assert property (@(posedge clk) disable iff (!rst_n)
        entry_cnt_reg <= MAX_CNT)
        else $error("entry count exceeds table size");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input not stalled after an accepted item");

endmodule

@@ test/tb_batch_buffer_first_fit_allocator.sv @@
module tb_batch_buffer_first_fit_allocator;
    import bbfa_pkg::*;

    localparam int TABLE_DEPTH = DEF_MAX_BATCHES;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 235;

    typedef struct packed {
        logic [CAP_W-1:0] vcap;
        logic [CAP_W-1:0] icap;
        logic [CAP_W-1:0] vcur;
        logic [CAP_W-1:0] icur;
        logic [OUT_ID_W-1:0] id;
    } batch_t;

    typedef struct packed {
        logic [OUT_ID_W-1:0] slot;
        logic [OUT_ID_W-1:0] buffer_id;
        logic [CNT_W-1:0] vertex_base;
        logic [CNT_W-1:0] index_base;
        logic created;
        logic status;
    } grant_t;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CAP_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic func = FUNC_RESERVE;
    logic [CNT_W-1:0] vertex_count = '0;
    logic [CNT_W-1:0] index_count = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [OUT_ID_W-1:0] slot;
    logic [OUT_ID_W-1:0] buffer_id;
    logic [CNT_W-1:0] vertex_base;
    logic [CNT_W-1:0] index_base;
    logic created;
    logic status;

    batch_t batches [TABLE_DEPTH];
    int active_n;
    int entry_n;
    logic [CAP_W-1:0] dflt_vcap;
    logic [CAP_W-1:0] dflt_icap;
    grant_t pending_grants [$];
    grant_t want;

    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int created_seen = 0;
    int refused_seen = 0;
    int settings_used = 0;
    int burst_left = 8;
    bit gaps_enabled = 1'b1;
    int hold_left = 0;

    batch_buffer_first_fit_allocator #(
        .MAX_BATCHES(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .vertex_count(vertex_count),
        .index_count(index_count),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .slot(slot),
        .buffer_id(buffer_id),
        .vertex_base(vertex_base),
        .index_base(index_base),
        .created(created),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 2000000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic grant_t allocate_batch(input logic f, input logic [CNT_W-1:0] nv,
                                              input logic [CNT_W-1:0] ni);
        grant_t g;
        batch_t tmp;
        int pick;
        int k;
        int vc;
        int ic;
        g = '0;
        pick = -1;
        if (f == FUNC_NEW_FRAME)
        begin
            active_n = 0;
            return g;
        end
        for (k = 0; k < active_n; k++)
        begin
            if (int'(batches[k].vcap) - int'(batches[k].vcur) >= int'(nv) &&
                int'(batches[k].icap) - int'(batches[k].icur) >= int'(ni))
            begin
                pick = k;
                break;
            end
        end
        if (pick < 0)
        begin
            for (k = active_n; k < entry_n; k++)
            begin
                if (batches[k].vcap >= nv && batches[k].icap >= ni)
                begin
                    batches[k].vcur = '0;
                    batches[k].icur = '0;
                    tmp = batches[active_n];
                    batches[active_n] = batches[k];
                    batches[k] = tmp;
                    pick = active_n;
                    active_n++;
                    break;
                end
            end
        end
        if (pick < 0)
        begin
            if (entry_n >= TABLE_DEPTH)
            begin
                g.status = 1'b1;
                return g;
            end
            vc = 1;
            while (vc < int'(nv))
                vc = vc << 1;
            ic = 1;
            while (ic < int'(ni))
                ic = ic << 1;
            if (vc < int'(dflt_vcap))
                vc = int'(dflt_vcap);
            if (ic < int'(dflt_icap))
                ic = int'(dflt_icap);
            batches[entry_n].vcap = vc[CAP_W-1:0];
            batches[entry_n].icap = ic[CAP_W-1:0];
            batches[entry_n].vcur = '0;
            batches[entry_n].icur = '0;
            batches[entry_n].id = entry_n[OUT_ID_W-1:0];
            tmp = batches[active_n];
            batches[active_n] = batches[entry_n];
            batches[entry_n] = tmp;
            entry_n++;
            pick = active_n;
            active_n++;
            g.created = 1'b1;
        end
        g.slot = pick[OUT_ID_W-1:0];
        g.buffer_id = batches[pick].id;
        g.vertex_base = batches[pick].vcur[CAP_W-1] ? '1 : batches[pick].vcur[CNT_W-1:0];
        g.index_base = batches[pick].icur[CAP_W-1] ? '1 : batches[pick].icur[CNT_W-1:0];
        batches[pick].vcur = batches[pick].vcur + nv;
        batches[pick].icur = batches[pick].icur + ni;
        return g;
    endfunction

    function automatic logic [CNT_W-1:0] random_count();
        int sel;
        int sh;
        sel = $urandom_range(0, 99);
        sh = $urandom_range(0, 15);
        if (sel < 45)
            return CNT_W'($urandom_range(0, 255));
        else if (sel < 70)
            return CNT_W'($urandom_range(0, 4095));
        else if (sel < 85)
            return CNT_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return CNT_W'(1 << sh);
            3: return CNT_W'((1 << sh) - 1);
            default: return CNT_W'((1 << sh) + 1);
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [CNT_W-1:0] exp_v,
                                          input logic [CNT_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_grants.size() == 0)
            begin
                $display("%0t: result item with nothing expected: expected none, actual slot %0d",
                         $time, slot);
                errors++;
            end
            else
            begin
                want = pending_grants.pop_front();
                results_checked++;
                if (want.created)
                    created_seen++;
                if (want.status)
                    refused_seen++;
                compare_field("slot", CNT_W'(want.slot), CNT_W'(slot));
                compare_field("buffer_id", CNT_W'(want.buffer_id), CNT_W'(buffer_id));
                compare_field("vertex_base", want.vertex_base, vertex_base);
                compare_field("index_base", want.index_base, index_base);
                compare_field("created", CNT_W'(want.created), CNT_W'(created));
                compare_field("status", CNT_W'(want.status), CNT_W'(status));
            end
        end
    end

    // The receiver switches between its own stall patterns; a requested hold overrides them.
    initial
    begin : receiver
        int mode;
        int mode_left;
        int beat;
        mode = 0;
        mode_left = 100;
        beat = 0;
        forever
        begin
            @(posedge clk);
            beat++;
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 400);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 9) < 6);
                    default: out_stall <= ((beat % 7) < 3);
                endcase
            end
        end
    end

    task automatic send_item(input logic f, input logic [CNT_W-1:0] nv,
                             input logic [CNT_W-1:0] ni);
        int gap;
        in_valid <= 1'b1;
        func <= f;
        vertex_count <= nv;
        index_count <= ni;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_grants.push_back(allocate_batch(f, nv, ni));
        items_sent++;
        if (gaps_enabled && burst_left <= 0)
        begin
            in_valid <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        else
            burst_left--;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_defaults(input logic [CAP_W-1:0] vcap_v,
                                  input logic [CAP_W-1:0] icap_v);
        cfg_we <= 1'b1;
        cfg_index <= CFG_DEF_VCAP;
        cfg_data <= vcap_v;
        @(posedge clk);
        cfg_index <= CFG_DEF_ICAP;
        cfg_data <= icap_v;
        @(posedge clk);
        cfg_we <= 1'b0;
        dflt_vcap = vcap_v;
        dflt_icap = icap_v;
        settings_used++;
    endtask

    task automatic test_directed_cases();
        write_defaults(17'd65536, 17'd65536);
        send_item(FUNC_RESERVE, 16'hFFFF, 16'hFFFF);
        send_item(FUNC_RESERVE, 16'd1, 16'd1);
        // The cursor now sits at 65536, so the next base saturates.
        send_item(FUNC_RESERVE, 16'd0, 16'd0);
        drain();
        write_defaults(17'd1, 17'd1);
        send_item(FUNC_RESERVE, 16'd1, 16'd0);
        send_item(FUNC_RESERVE, 16'd0, 16'd1);
        send_item(FUNC_NEW_FRAME, 16'hFFFF, 16'hFFFF);
        send_item(FUNC_RESERVE, 16'hFFFF, 16'hFFFF);
        send_item(FUNC_RESERVE, 16'd2, 16'd2);
        send_item(FUNC_RESERVE, 16'd1, 16'd1);
        send_item(FUNC_RESERVE, 16'd0, 16'd0);
        send_item(FUNC_NEW_FRAME, 16'd0, 16'd0);
        send_item(FUNC_RESERVE, 16'd1, 16'd1);
        drain();
    endtask

    task automatic test_output_backpressure();
        int k;
        gaps_enabled = 1'b0;
        hold_left = 200;
        send_item(FUNC_NEW_FRAME, 16'd0, 16'd0);
        for (k = 0; k < 12; k++)
            send_item(FUNC_RESERVE, random_count(), random_count());
        drain();
        gaps_enabled = 1'b1;
    endtask

    task automatic test_random_frames();
        int p;
        int n;
        int k;
        int frame_len;
        int sh;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            sh = $urandom_range(0, 16);
            case (p)
                0: write_defaults(17'd1, 17'd1);
                1: write_defaults(17'd65536, 17'd65536);
                2: write_defaults(DEF_VCAP_RESET, DEF_ICAP_RESET);
                3: write_defaults(CAP_W'(1 << sh), CAP_W'($urandom_range(1, 65536)));
                default: write_defaults(CAP_W'($urandom_range(1, 65536)),
                                        CAP_W'($urandom_range(1, 65536)));
            endcase
            gaps_enabled = (p % 3) != 1;
            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                frame_len = $urandom_range(1, 30);
                send_item(FUNC_NEW_FRAME, random_count(), random_count());
                n++;
                for (k = 0; k < frame_len; k++)
                begin
                    send_item(FUNC_RESERVE, random_count(), random_count());
                    n++;
                end
            end
        end
        gaps_enabled = 1'b1;
        drain();
    endtask

    task automatic test_table_full();
        int k;
        write_defaults(17'd65536, 17'd65536);
        send_item(FUNC_NEW_FRAME, 16'd0, 16'd0);
        for (k = 0; k < TABLE_DEPTH + 2; k++)
            send_item(FUNC_RESERVE, 16'hFFFF, 16'hFFFF);
        send_item(FUNC_RESERVE, 16'd0, 16'd0);
        send_item(FUNC_RESERVE, 16'd2, 16'd2);
        drain();
    endtask

    initial
    begin
        active_n = 0;
        entry_n = 0;
        dflt_vcap = DEF_VCAP_RESET;
        dflt_icap = DEF_ICAP_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_output_backpressure();
        test_random_frames();
        test_table_full();
        $display("Sent %0d items and checked %0d results under %0d register settings.",
                 items_sent, results_checked, settings_used);
        $display("Buffers created: %0d; requests refused on a full table: %0d.",
                 created_seen, refused_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/bbfa_pkg.sv
hdl/bbfa_ram.sv
hdl/bbfa_fit.sv
hdl/batch_buffer_first_fit_allocator.sv
test/tb_batch_buffer_first_fit_allocator.sv
